/* rtl/seg_isect_pkg.sv */
`timescale 1ns / 1ps

package seg_isect_pkg;

    // Coordinate and fraction widths of the payload.
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int XY_BITS    = COORD_BITS + FRAC_BITS;

    // One pair of segments, given by their integer end points.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } seg_pair_t;

    // Hit flag and crossing point in signed fixed point.
    typedef struct packed {
        logic                      hit;
        logic signed [XY_BITS-1:0] cross_x;
        logic signed [XY_BITS-1:0] cross_y;
    } seg_hit_t;

endpackage

/* rtl/segment_intersection.sv */
`timescale 1ns / 1ps

// Two-dimensional segment intersection, fully pipelined. The block takes one
// transaction per clock cycle unless an output stall holds it back, and
// passes each one through three arithmetic stages (differences, cross products,
// denominator), a normalising stage, a multiply stage, one restoring divider
// stage per quotient bit (COORD_BITS + 1 + FRAC_BITS of them) and an output
// register. Every stage holds its own valid bit and moves on whenever the
// stage after it is empty or moving, so a stalled output fills the bubbles
// first and only then holds back the input. Parallel, collinear and
// zero-length segments never hit; end points count as inside. The crossing
// point is rounded toward minus infinity and reads as zero when there is no
// hit.
module segment_intersection
    import seg_isect_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  seg_pair_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output seg_hit_t  out_data
);

    localparam int DW     = COORD_BITS + 1;   // coordinate difference
    localparam int PW     = 2 * DW;           // cross product
    localparam int NW     = PW + 1;           // difference of two products
    localparam int UW     = NW;               // magnitudes after normalising
    localparam int QW     = DW + FRAC_BITS;   // quotient bits
    localparam int MW     = QW + UW;          // dividend
    localparam int NS     = QW + 6;           // number of pipeline stages
    localparam int S_DIFF = 0;
    localparam int S_PROD = 1;
    localparam int S_DEN  = 2;
    localparam int S_NORM = 3;
    localparam int S_MUL  = 4;
    localparam int S_OUT  = NS - 1;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   adv;

    // Each stage advances when it is empty or the next stage advances.
    assign adv[NS] = out_ready;
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_adv
            assign adv[k] = !valid_reg[k] || adv[k+1];
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[S_OUT];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage one: direction vectors and the offset between start points.
    logic signed [DW-1:0]         dx1_reg, dy1_reg, dx2_reg, dy2_reg, wx_reg, wy_reg;
    logic signed [COORD_BITS-1:0] bx_a_reg, by_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_DIFF])
        begin
            dx1_reg  <= DW'(in_data.first_end_x) - DW'(in_data.first_start_x);
            dy1_reg  <= DW'(in_data.first_end_y) - DW'(in_data.first_start_y);
            dx2_reg  <= DW'(in_data.second_end_x) - DW'(in_data.second_start_x);
            dy2_reg  <= DW'(in_data.second_end_y) - DW'(in_data.second_start_y);
            wx_reg   <= DW'(in_data.second_start_x) - DW'(in_data.first_start_x);
            wy_reg   <= DW'(in_data.second_start_y) - DW'(in_data.first_start_y);
            bx_a_reg <= in_data.first_start_x;
            by_a_reg <= in_data.first_start_y;
        end
    end

    // Stage two: the six cross products.
    logic signed [PW-1:0]         pda_reg, pdb_reg, pta_reg, ptb_reg, pua_reg, pub_reg;
    logic signed [DW-1:0]         dx1_b_reg, dy1_b_reg;
    logic signed [COORD_BITS-1:0] bx_b_reg, by_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_PROD])
        begin
            pda_reg   <= dx1_reg * dy2_reg;
            pdb_reg   <= dy1_reg * dx2_reg;
            pta_reg   <= wx_reg * dy2_reg;
            ptb_reg   <= wy_reg * dx2_reg;
            pua_reg   <= wx_reg * dy1_reg;
            pub_reg   <= wy_reg * dx1_reg;
            dx1_b_reg <= dx1_reg;
            dy1_b_reg <= dy1_reg;
            bx_b_reg  <= bx_a_reg;
            by_b_reg  <= by_a_reg;
        end
    end

    // Stage three: denominator and the two line parameter numerators.
    logic signed [NW-1:0]         den_reg, tn_reg, un_reg;
    logic signed [DW-1:0]         dx1_c_reg, dy1_c_reg;
    logic signed [COORD_BITS-1:0] bx_c_reg, by_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_DEN])
        begin
            den_reg   <= NW'(pda_reg) - NW'(pdb_reg);
            tn_reg    <= NW'(pta_reg) - NW'(ptb_reg);
            un_reg    <= NW'(pua_reg) - NW'(pub_reg);
            dx1_c_reg <= dx1_b_reg;
            dy1_c_reg <= dy1_b_reg;
            bx_c_reg  <= bx_b_reg;
            by_c_reg  <= by_b_reg;
        end
    end

    // Stage four: make the denominator positive and test both spans.
    logic signed [NW-1:0] den_p, tn_p, un_p;
    logic                 hit_next;

    always_comb
    begin
        den_p    = den_reg[NW-1] ? -den_reg : den_reg;
        tn_p     = den_reg[NW-1] ? -tn_reg  : tn_reg;
        un_p     = den_reg[NW-1] ? -un_reg  : un_reg;
        hit_next = (den_reg != '0) && !tn_p[NW-1] && (tn_p <= den_p)
                   && !un_p[NW-1] && (un_p <= den_p);
    end

    logic [UW-1:0]                dmag_reg, tmag_reg;
    logic [DW-1:0]                magx_reg, magy_reg;
    logic                         negx_n_reg, negy_n_reg, hit_n_reg;
    logic signed [COORD_BITS-1:0] bx_n_reg, by_n_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_NORM])
        begin
            dmag_reg   <= UW'(den_p);
            tmag_reg   <= UW'(tn_p);
            magx_reg   <= dx1_c_reg[DW-1] ? DW'(-dx1_c_reg) : DW'(dx1_c_reg);
            magy_reg   <= dy1_c_reg[DW-1] ? DW'(-dy1_c_reg) : DW'(dy1_c_reg);
            negx_n_reg <= dx1_c_reg[DW-1];
            negy_n_reg <= dy1_c_reg[DW-1];
            hit_n_reg  <= hit_next;
            bx_n_reg   <= bx_c_reg;
            by_n_reg   <= by_c_reg;
        end
    end

    // Divider pipeline, one quotient bit per stage; entry zero is the multiply.
    logic [UW-1:0]                rx_reg [0:QW];
    logic [UW-1:0]                ry_reg [0:QW];
    logic [QW-1:0]                lx_reg [0:QW];
    logic [QW-1:0]                ly_reg [0:QW];
    logic [QW-1:0]                qx_reg [0:QW];
    logic [QW-1:0]                qy_reg [0:QW];
    logic [UW-1:0]                dd_reg [0:QW];
    logic                         negx_reg [0:QW];
    logic                         negy_reg [0:QW];
    logic                         hit_reg  [0:QW];
    logic signed [COORD_BITS-1:0] bx_reg   [0:QW];
    logic signed [COORD_BITS-1:0] by_reg   [0:QW];

    // Stage five: dividends are the span length times the numerator, scaled.
    logic [DW+UW-1:0] prodx, prody;
    logic [MW-1:0]    numx, numy;

    always_comb
    begin
        prodx = (DW+UW)'(magx_reg) * (DW+UW)'(tmag_reg);
        prody = (DW+UW)'(magy_reg) * (DW+UW)'(tmag_reg);
        numx  = {prodx, {FRAC_BITS{1'b0}}};
        numy  = {prody, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_MUL])
        begin
            rx_reg[0]   <= numx[MW-1:QW];
            lx_reg[0]   <= numx[QW-1:0];
            ry_reg[0]   <= numy[MW-1:QW];
            ly_reg[0]   <= numy[QW-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            dd_reg[0]   <= dmag_reg;
            negx_reg[0] <= negx_n_reg;
            negy_reg[0] <= negy_n_reg;
            hit_reg[0]  <= hit_n_reg;
            bx_reg[0]   <= bx_n_reg;
            by_reg[0]   <= by_n_reg;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= QW; j++) begin : g_div
            logic [UW:0] tx, ty;
            logic        gex, gey;

            // Shift in the next dividend bit and subtract where it fits.
            always_comb
            begin
                tx  = {rx_reg[j-1], lx_reg[j-1][QW-1]};
                ty  = {ry_reg[j-1], ly_reg[j-1][QW-1]};
                gex = tx >= {1'b0, dd_reg[j-1]};
                gey = ty >= {1'b0, dd_reg[j-1]};
            end

            always_ff @(posedge clk)
            begin
                if (adv[S_MUL+j])
                begin
                    rx_reg[j]   <= gex ? UW'(tx - {1'b0, dd_reg[j-1]}) : UW'(tx);
                    ry_reg[j]   <= gey ? UW'(ty - {1'b0, dd_reg[j-1]}) : UW'(ty);
                    lx_reg[j]   <= {lx_reg[j-1][QW-2:0], 1'b0};
                    ly_reg[j]   <= {ly_reg[j-1][QW-2:0], 1'b0};
                    qx_reg[j]   <= {qx_reg[j-1][QW-2:0], gex};
                    qy_reg[j]   <= {qy_reg[j-1][QW-2:0], gey};
                    dd_reg[j]   <= dd_reg[j-1];
                    negx_reg[j] <= negx_reg[j-1];
                    negy_reg[j] <= negy_reg[j-1];
                    hit_reg[j]  <= hit_reg[j-1];
                    bx_reg[j]   <= bx_reg[j-1];
                    by_reg[j]   <= by_reg[j-1];
                end
            end
        end
    endgenerate

    // Output stage: apply the direction sign, flooring on a remainder.
    logic signed [XY_BITS+1:0] qex, qey, offx, offy, basex, basey, sumx, sumy;
    seg_hit_t                  out_next;

    always_comb
    begin
        qex   = $signed({1'b0, qx_reg[QW]});
        qey   = $signed({1'b0, qy_reg[QW]});
        offx  = negx_reg[QW] ? -(qex + (XY_BITS+2)'(rx_reg[QW] != '0)) : qex;
        offy  = negy_reg[QW] ? -(qey + (XY_BITS+2)'(ry_reg[QW] != '0)) : qey;
        basex = $signed({{2{bx_reg[QW][COORD_BITS-1]}}, bx_reg[QW], {FRAC_BITS{1'b0}}});
        basey = $signed({{2{by_reg[QW][COORD_BITS-1]}}, by_reg[QW], {FRAC_BITS{1'b0}}});
        sumx  = basex + offx;
        sumy  = basey + offy;
        out_next.hit     = hit_reg[QW];
        out_next.cross_x = hit_reg[QW] ? sumx[XY_BITS-1:0] : '0;
        out_next.cross_y = hit_reg[QW] ? sumy[XY_BITS-1:0] : '0;
    end

    seg_hit_t out_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    // A result without a hit carries a zero point.
    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.cross_x == '0 && out_data.cross_y == '0)
        else $error("no-hit result carries a non-zero point");

    // For a hit, the divider remainder stays below the divisor.
    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_OUT-1] && hit_reg[QW] |->
            rx_reg[QW] < dd_reg[QW] && ry_reg[QW] < dd_reg[QW])
        else $error("divider remainder not below divisor");

    // With the output register empty the whole pipe can move.
    a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held back while output is empty");

endmodule

/* bench/tb_segment_intersection.sv */
`timescale 1ns / 1ps

module tb_segment_intersection;
    import seg_isect_pkg::*;

    localparam int N_RANDOM  = 1800;
    localparam int LATENCY   = 31;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    seg_pair_t in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    seg_hit_t  out_data;

    seg_hit_t  crossings_due[$];
    int        errors = 0;
    bit        stim_done = 1'b0;
    bit        hold_off = 1'b0;

    segment_intersection u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Floor of base*2^F + delta*tn*2^F/den, with tn >= 0 and den > 0.
    function automatic logic signed [XY_BITS-1:0] place_point(
        longint base, longint delta, longint tn, longint den);
        logic signed [127:0] num;
        logic signed [127:0] q;
        logic signed [127:0] full;
        begin
            num = 128'(delta) * 128'(tn) * (128'sd1 <<< FRAC_BITS);
            q = num / 128'(den);
            if (num < 0 && q * 128'(den) != num)
                q = q - 1;
            full = 128'(base) * (128'sd1 <<< FRAC_BITS) + q;
            place_point = full[XY_BITS-1:0];
        end
    endfunction

    // Predicted crossing of the two segments.
    function automatic seg_hit_t predict_crossing(seg_pair_t p);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dx1, dy1, dx2, dy2, wx, wy, den, tn, un;
        seg_hit_t r;
        begin
            x1 = p.first_start_x;  y1 = p.first_start_y;
            x2 = p.first_end_x;    y2 = p.first_end_y;
            x3 = p.second_start_x; y3 = p.second_start_y;
            x4 = p.second_end_x;   y4 = p.second_end_y;
            dx1 = x2 - x1; dy1 = y2 - y1;
            dx2 = x4 - x3; dy2 = y4 - y3;
            wx = x3 - x1;  wy = y3 - y1;
            den = dx1 * dy2 - dy1 * dx2;
            tn = wx * dy2 - wy * dx2;
            un = wx * dy1 - wy * dx1;
            r = '0;
            if (den != 0)
            begin
                if (den < 0)
                begin
                    den = -den;
                    tn = -tn;
                    un = -un;
                end
                if (tn >= 0 && tn <= den && un >= 0 && un <= den)
                begin
                    r.hit = 1'b1;
                    r.cross_x = place_point(x1, dx1, tn, den);
                    r.cross_y = place_point(y1, dy1, tn, den);
                end
            end
            predict_crossing = r;
        end
    endfunction

    function automatic seg_pair_t mk_pair(int a, int b, int c, int d,
                                          int e, int f, int g, int h);
        seg_pair_t p;
        begin
            p.first_start_x = a[15:0];  p.first_start_y = b[15:0];
            p.first_end_x = c[15:0];    p.first_end_y = d[15:0];
            p.second_start_x = e[15:0]; p.second_start_y = f[15:0];
            p.second_end_x = g[15:0];   p.second_end_y = h[15:0];
            mk_pair = p;
        end
    endfunction

    // Coordinate drawn mostly from a small box so that segments often cross.
    function automatic logic [15:0] rand_coord();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                rand_coord = 16'($signed($urandom_range(0, 200)) - 100);
            else if (sel < 8)
                rand_coord = 16'($urandom);
            else
                rand_coord = sel[0] ? 16'h7fff : 16'h8000;
        end
    endfunction

    // Offers one transaction and waits for its acceptance. Valid stays high
    // into the next transaction unless an idle cycle is taken.
    task automatic send_pair(seg_pair_t p, bit idle_ok);
        begin
            while (idle_ok && $urandom_range(0, 99) < 18)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= p;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            crossings_due.push_back(predict_crossing(p));
            @(negedge clk);
        end
    endtask

    // Directed rows: inputs and, where obvious, the expected result.
    typedef struct {
        seg_pair_t p;
        bit        fixed;
        seg_hit_t  want;
    } row_t;

    row_t rows[$];

    initial
    begin
        seg_pair_t p;
        row_t r;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Plain cross at the origin, zero-length, parallel, collinear overlap.
        rows.push_back('{mk_pair(-10, 0, 10, 0, 0, -10, 0, 10), 1, '{1'b1, 24'd0, 24'd0}});
        rows.push_back('{mk_pair(5, 5, 5, 5, 0, 0, 9, 9), 1, '0});
        rows.push_back('{mk_pair(0, 0, 10, 0, 0, 1, 10, 1), 1, '0});
        rows.push_back('{mk_pair(0, 0, 10, 0, 5, 0, 20, 0), 1, '0});
        // Touching at end points, and missing just past one.
        rows.push_back('{mk_pair(0, 0, 4, 4, 4, 4, 8, 0), 1, '{1'b1, 24'h400, 24'h400}});
        rows.push_back('{mk_pair(0, 0, 4, 0, 5, -1, 5, 1), 1, '0});
        // Extremes of the coordinate range.
        rows.push_back('{mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0, '0});
        rows.push_back('{mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1, '{1'b1, 24'd0, 24'd0}});
        rows.push_back('{mk_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767), 0, '0});
        rows.push_back('{mk_pair(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 0), 0, '0});
        // Fractional points with negative direction, to exercise flooring, and a fully degenerate pair.
        rows.push_back('{mk_pair(0, 0, 3, -1, 1, -3, 1, 3), 0, '0});
        rows.push_back('{mk_pair(3, 1, 0, 0, 1, 3, 1, -3), 0, '0});
        rows.push_back('{mk_pair(0, 0, -7, 3, -1, -5, -2, 9), 0, '0});
        rows.push_back('{mk_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1, '0});
        foreach (rows[i])
        begin
            send_pair(rows[i].p, 1'b0);
            if (rows[i].fixed && rows[i].want != crossings_due[$])
            begin
                $error("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            if ($urandom_range(0, 9) == 0)
                p = $urandom_range(0, 1) ? {8{16'h8000}} ^ {$urandom, $urandom, $urandom, $urandom}
                                         : {$urandom, $urandom, $urandom, $urandom};
            // Back to back with no idling over one stretch.
            send_pair(p, !(n >= 600 && n < 900));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, a long hold-off while the sender runs, and a stall-free stretch.
    initial
    begin
        int cyc;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            hold_off = (cyc >= 200 && cyc < 300);
            if (hold_off)
                out_ready <= 1'b0;
            else if (cyc > 3000 && cyc < 4000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 18);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        seg_hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (crossings_due.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                want = crossings_due.pop_front();
                if (out_data.hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, out_data.hit);
                    errors++;
                end
                if (out_data.cross_x !== want.cross_x)
                begin
                    $error("cross_x: expected %0d, actual %0d", want.cross_x, out_data.cross_x);
                    errors++;
                end
                if (out_data.cross_y !== want.cross_y)
                begin
                    $error("cross_y: expected %0d, actual %0d", want.cross_y, out_data.cross_y);
                    errors++;
                end
            end
        end
    end

    // End of run.
    initial
    begin
        wait (stim_done);
        while (crossings_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && crossings_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
